@@ design/rrod_pkg.sv @@
// Shared constants, types and helper functions of the record ring block.
package rrod_pkg;

	// Ring geometry
	localparam int RING_BYTES  = 2048;
	localparam int ALIGN_BYTES = 4;
	localparam int AW          = $clog2(RING_BYTES);
	localparam int CW          = $clog2(RING_BYTES + 1);

	// Field widths of the item and the result
	localparam int SPACE_W = 12;
	localparam int BATCH_W = 12;
	localparam int DROP_W  = 10;
	localparam int ALN_W   = 9;
	localparam int WW      = ((CW > SPACE_W) ? CW : SPACE_W) + 1;

	// Item kinds
	typedef enum logic [1:0] {
		KIND_PUSH  = 2'd0,
		KIND_DRAIN = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic evict_drop;
		logic note_start;
		logic note_cont;
		logic pad_wr;
		logic commit;
		logic drain_take_all;
		logic drain_step;
		logic drain_fin;
		logic read_out;
		logic done;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic note_active;
		logic byte_zero_in;
		logic evict_more;
		logic one_byte_note;
		logic last_byte;
		logic pad_done;
		logic whole_fits;
		logic walk_stop;
	} sts_t;

	// Round a record length up to the alignment boundary
	function automatic logic [ALN_W-1:0] align_up(logic [7:0] n);
		logic [ALN_W-1:0] s;
		s = ALN_W'(n) + ALN_W'(ALIGN_BYTES - 1);
		return ALN_W'((s / ALIGN_BYTES) * ALIGN_BYTES);
	endfunction

	// Advance a ring position by an offset of at most RING_BYTES
	function automatic logic [AW-1:0] ring_adv(logic [AW-1:0] pos, logic [CW-1:0] off);
		logic [CW:0] s;
		s = (CW+1)'(pos) + (CW+1)'(off);
		if (s >= (CW+1)'(RING_BYTES)) begin
			s = s - (CW+1)'(RING_BYTES);
		end
		return s[AW-1:0];
	endfunction

endpackage

@@ design/rrod_ctrl.sv @@
// Controller state machine: sequences eviction, note writes, padding, drain walk and reads.
module rrod_ctrl import rrod_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] kind,
	input  sts_t       sts,
	output cmd_t       cmd,
	output logic       busy
);

	typedef enum logic [7:0] {
		S_IDLE      = 8'b0000_0001,
		S_EVICT     = 8'b0000_0010,
		S_WR        = 8'b0000_0100,
		S_PAD       = 8'b0000_1000,
		S_DRAIN     = 8'b0001_0000,
		S_DRAIN_FIN = 8'b0010_0000,
		S_READ      = 8'b0100_0000,
		S_NULL      = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	// Decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					case (kind)
						KIND_PUSH: begin
							if (sts.note_active) begin
								state_d = S_WR;
							end else if (sts.byte_zero_in) begin
								state_d = S_NULL;
							end else begin
								state_d = S_EVICT;
							end
						end
						KIND_DRAIN: state_d = S_DRAIN;
						KIND_READ:  state_d = S_READ;
						default:    state_d = S_NULL;
					endcase
				end
			end
			S_EVICT: begin
				if (sts.evict_more) begin
					cmd.evict_drop = 1'b1;
				end else begin
					cmd.note_start = 1'b1;
					if (sts.one_byte_note) begin
						state_d = S_PAD;
					end else begin
						cmd.done = 1'b1;
						state_d  = S_IDLE;
					end
				end
			end
			S_WR: begin
				cmd.note_cont = 1'b1;
				if (sts.last_byte) begin
					state_d = S_PAD;
				end else begin
					cmd.done = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_PAD: begin
				if (!sts.pad_done) begin
					cmd.pad_wr = 1'b1;
				end else begin
					cmd.commit = 1'b1;
					cmd.done   = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_DRAIN: begin
				if (sts.whole_fits) begin
					cmd.drain_take_all = 1'b1;
					state_d            = S_DRAIN_FIN;
				end else if (sts.walk_stop) begin
					state_d = S_DRAIN_FIN;
				end else begin
					cmd.drain_step = 1'b1;
				end
			end
			S_DRAIN_FIN: begin
				cmd.drain_fin = 1'b1;
				cmd.done      = 1'b1;
				state_d       = S_IDLE;
			end
			S_READ: begin
				cmd.read_out = 1'b1;
				cmd.done     = 1'b1;
				state_d      = S_IDLE;
			end
			S_NULL: begin
				cmd.done = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ design/rrod_dp.sv @@
// Datapath: byte ring memory, ring pointers, fill count, walk registers and result registers.
module rrod_dp import rrod_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic [1:0]         kind,
	input  logic [7:0]         note_byte,
	input  logic [SPACE_W-1:0] drain_space,
	output sts_t               sts,
	output logic [7:0]         read_byte,
	output logic [BATCH_W-1:0] batch_bytes,
	output logic               end_of_batch,
	output logic [DROP_W-1:0]  records_dropped,
	output logic               done
);

	logic [7:0] ring_mem [RING_BYTES];

	// Control state
	logic [AW-1:0]      head_q;
	logic [AW-1:0]      tail_q;
	logic [AW-1:0]      bri_q;
	logic [CW-1:0]      fill_q;
	logic [CW-1:0]      batch_left_q;
	logic [7:0]         note_left_q;
	logic               done_q;

	// Working registers
	logic [7:0]         nb_q;
	logic [SPACE_W-1:0] space_q;
	logic [AW-1:0]      pos_q;
	logic [CW-1:0]      acc_q;
	logic [ALN_W-1:0]   k_q;
	logic [7:0]         note_len_q;
	logic [DROP_W-1:0]  count_q;
	logic [7:0]         rdata_q;

	// Result registers
	logic [7:0]         read_byte_q;
	logic [BATCH_W-1:0] batch_q;
	logic               eob_q;
	logic [DROP_W-1:0]  dropped_q;

	// Combinational values
	logic [ALN_W-1:0]   need;
	logic [ALN_W-1:0]   rd_aln;
	logic [ALN_W-1:0]   len_aln;
	logic [CW-1:0]      evict_adv;
	logic [AW-1:0]      tail_evict;
	logic [WW-1:0]      acc_nxt;
	logic [AW-1:0]      pos_nxt;
	logic [7:0]         cont_off;
	logic [WW-1:0]      fill_sum;
	logic [CW-1:0]      fill_cmt;
	logic [AW-1:0]      raddr;
	logic [AW-1:0]      waddr;
	logic [7:0]         wdata;
	logic               we;

	assign need     = align_up(nb_q);
	assign rd_aln   = align_up(rdata_q);
	assign len_aln  = align_up(note_len_q);
	assign cont_off = note_len_q - note_left_q;

	// Eviction step: a corrupt length takes everything committed
	assign evict_adv  = ((rd_aln == '0) || (WW'(rd_aln) > WW'(fill_q))) ? fill_q : CW'(rd_aln);
	assign tail_evict = ring_adv(tail_q, evict_adv);

	// Drain walk step
	assign acc_nxt = WW'(acc_q) + WW'(rd_aln);
	assign pos_nxt = ring_adv(pos_q, CW'(rd_aln));

	// Commit with saturation of the fill count
	assign fill_sum = WW'(fill_q) + WW'(len_aln);
	assign fill_cmt = (fill_sum > WW'(RING_BYTES)) ? CW'(RING_BYTES) : fill_sum[CW-1:0];

	// Status to the controller
	always_comb begin
		sts.note_active   = (note_left_q != '0);
		sts.byte_zero_in  = (note_byte == '0);
		sts.evict_more    = ((WW'(fill_q) + WW'(need)) > WW'(RING_BYTES)) && (fill_q != '0);
		sts.one_byte_note = (nb_q == 8'd1);
		sts.last_byte     = (note_left_q == 8'd1);
		sts.pad_done      = (k_q >= len_aln);
		sts.whole_fits    = (WW'(space_q) >= WW'(fill_q));
		sts.walk_stop     = (rd_aln == '0) || (acc_nxt > WW'(fill_q)) ||
		                    (acc_nxt > WW'(space_q));
	end

	// Select the read address for the next cycle
	always_comb begin
		if (cmd.accept) begin
			raddr = (kind == KIND_READ) ? bri_q : tail_q;
		end else if (cmd.evict_drop) begin
			raddr = tail_evict;
		end else if (cmd.drain_step) begin
			raddr = pos_nxt;
		end else begin
			raddr = tail_q;
		end
	end

	// Select the write port
	always_comb begin
		we    = 1'b0;
		waddr = head_q;
		wdata = nb_q;
		if (cmd.note_start) begin
			we = 1'b1;
		end else if (cmd.note_cont) begin
			we    = 1'b1;
			waddr = ring_adv(head_q, CW'(cont_off));
		end else if (cmd.pad_wr) begin
			we    = 1'b1;
			waddr = ring_adv(head_q, CW'(k_q));
			wdata = '0;
		end
	end

	// Ring memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (we) begin
			ring_mem[waddr] <= wdata;
		end
		rdata_q <= ring_mem[raddr];
	end

	// Advance pointers, counts and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			bri_q        <= '0;
			fill_q       <= '0;
			batch_left_q <= '0;
			note_left_q  <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= cmd.done;
			if (cmd.evict_drop) begin
				tail_q <= tail_evict;
				fill_q <= fill_q - evict_adv;
			end else if (cmd.commit) begin
				head_q <= ring_adv(head_q, CW'(len_aln));
				fill_q <= fill_cmt;
			end else if (cmd.drain_fin) begin
				bri_q        <= tail_q;
				batch_left_q <= acc_q;
				tail_q       <= ring_adv(tail_q, acc_q);
				fill_q       <= fill_q - acc_q;
			end else if (cmd.read_out && (batch_left_q != '0)) begin
				bri_q        <= ring_adv(bri_q, CW'(1));
				batch_left_q <= batch_left_q - CW'(1);
			end
			if (cmd.note_start) begin
				note_left_q <= nb_q - 8'd1;
			end else if (cmd.note_cont) begin
				note_left_q <= note_left_q - 8'd1;
			end
		end
	end

	// Hold item fields and walk state
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			nb_q    <= note_byte;
			space_q <= drain_space;
			count_q <= '0;
			pos_q   <= tail_q;
			acc_q   <= '0;
		end
		if (cmd.evict_drop) begin
			count_q <= count_q + DROP_W'(1);
		end
		if (cmd.note_start) begin
			note_len_q <= nb_q;
			k_q        <= ALN_W'(nb_q);
		end else if (cmd.note_cont) begin
			k_q <= ALN_W'(note_len_q);
		end else if (cmd.pad_wr) begin
			k_q <= k_q + ALN_W'(1);
		end
		if (cmd.drain_take_all) begin
			acc_q <= fill_q;
		end else if (cmd.drain_step) begin
			acc_q <= acc_nxt[CW-1:0];
			pos_q <= pos_nxt;
		end
		if (cmd.done) begin
			read_byte_q <= (cmd.read_out && (batch_left_q != '0)) ? rdata_q : 8'd0;
			eob_q       <= cmd.read_out && (batch_left_q == CW'(1));
			batch_q     <= cmd.drain_fin ? BATCH_W'(acc_q) : '0;
			dropped_q   <= count_q;
		end
	end

	assign read_byte       = read_byte_q;
	assign batch_bytes     = batch_q;
	assign end_of_batch    = eob_q;
	assign records_dropped = dropped_q;
	assign done            = done_q;

endmodule

@@ design/record_ring_overwrite_drain.sv @@
// Top level of the variable-length record ring with overwrite of the oldest records.
// An item is taken when start is high and busy is low; its single result appears
// on the result ports for one cycle with done high, and must be captured then, as
// the receiver cannot hold it off. busy drops in the cycle that done is high, so
// a new item may be started in that cycle. A note start first evicts the oldest
// records until the note fits; the byte that completes a note is followed by the
// padding bytes and the commit; a drain walks the ring record by record when the
// whole ring does not fit the limit. The eviction and drain walks visit one
// record a cycle through the single read port of the ring memory.
// Ring bytes never written are not cleared after reset and must not be read.
module record_ring_overwrite_drain import rrod_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         kind,
	input  logic [7:0]         note_byte,
	input  logic [SPACE_W-1:0] drain_space,
	output logic               done,
	output logic [7:0]         read_byte,
	output logic [BATCH_W-1:0] batch_bytes,
	output logic               end_of_batch,
	output logic [DROP_W-1:0]  records_dropped
);

	cmd_t cmd;
	sts_t sts;

	// Sequence the work of each item
	rrod_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Hold the ring and compute results
	rrod_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.kind            (kind),
		.note_byte       (note_byte),
		.drain_space     (drain_space),
		.sts             (sts),
		.read_byte       (read_byte),
		.batch_bytes     (batch_bytes),
		.end_of_batch    (end_of_batch),
		.records_dropped (records_dropped),
		.done            (done)
	);

endmodule

@@ design/rrod_checker.sv @@
// Port-level checker of the record ring block and its bind to the top level.
module rrod_checker import rrod_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [BATCH_W-1:0] batch_bytes,
	input logic               end_of_batch,
	input logic [DROP_W-1:0]  records_dropped
);

	// A taken item keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("item taken but block not busy");

	// A result follows work in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without work in progress");

	// The block is free while a result is shown
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy while a result is shown");

	// Results never come in adjacent cycles
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results in adjacent cycles");

	// End of batch comes only from a read item
	a_eob_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(done && end_of_batch) |-> ((batch_bytes == '0) && (records_dropped == '0)))
		else $error("end of batch on a non-read result");

endmodule

bind record_ring_overwrite_drain rrod_checker u_rrod_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.batch_bytes     (batch_bytes),
	.end_of_batch    (end_of_batch),
	.records_dropped (records_dropped)
);

@@ bench/testbench.sv @@
// Self-checking testbench of the record ring with overwrite of the oldest records.
`timescale 1ns / 1ps

module testbench;
	import rrod_pkg::*;

	localparam logic [1:0] KIND_UNKNOWN = 2'd3;
	localparam int CYCLE_LIMIT = 6000000;
	localparam int SETTLE_CYCLES = 600;
	localparam int RANDOM_ITEMS = 800;

	// One result as the block should give it
	typedef struct packed {
		logic [7:0]         rd;
		logic [BATCH_W-1:0] batch;
		logic               eob;
		logic [DROP_W-1:0]  dropped;
	} ring_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [1:0]         kind = KIND_PUSH;
	logic [7:0]         note_byte = 8'h00;
	logic [SPACE_W-1:0] drain_space = '0;
	logic               busy;
	logic               done;
	logic [7:0]         read_byte;
	logic [BATCH_W-1:0] batch_bytes;
	logic               end_of_batch;
	logic [DROP_W-1:0]  records_dropped;

	// Shadow copy of the ring and its pointers
	logic [7:0]    shadow_ring [RING_BYTES];
	logic [AW-1:0] shadow_head = '0;
	logic [AW-1:0] shadow_tail = '0;
	logic [AW-1:0] shadow_read_pos = '0;
	logic [CW-1:0] shadow_fill = '0;
	logic [7:0]    shadow_note_left = '0;
	logic [CW-1:0] shadow_batch_left = '0;

	ring_result_t expected_ring_results [$];

	int  cycle_count = 0;
	int  mismatch_count = 0;
	int  items_sent = 0;
	int  ignored_items = 0;
	int  results_checked = 0;
	int  evicted_total = 0;
	int  largest_batch = 0;
	bit  idle_enable = 1'b1;

	record_ring_overwrite_drain DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.kind            (kind),
		.note_byte       (note_byte),
		.drain_space     (drain_space),
		.done            (done),
		.read_byte       (read_byte),
		.batch_bytes     (batch_bytes),
		.end_of_batch    (end_of_batch),
		.records_dropped (records_dropped)
	);

	// Clock: 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Count cycles for the timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles", cycle_count);
		$display("end of test: mismatches");
		$finish;
	end

	// Round a length up to whole slots
	function automatic int slot_len(input int n);
		return (n + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
	endfunction

	// Step a ring position forward with wrap
	function automatic logic [AW-1:0] wrap_pos(input int p, input int off);
		return AW'((p + off) % RING_BYTES);
	endfunction

	// Pad the finished note with zeros and advance head and fill
	function automatic void commit_shadow_note();
		int len;
		int alen;
		int k;
		int fill_sum;
		len = int'(shadow_ring[shadow_head]);
		alen = slot_len(len);
		for (k = len; k < alen; k++) begin
			shadow_ring[wrap_pos(int'(shadow_head), k)] = 8'h00;
		end
		shadow_head = wrap_pos(int'(shadow_head), alen);
		fill_sum = int'(shadow_fill) + alen;
		if (fill_sum > RING_BYTES) begin
			fill_sum = RING_BYTES;
		end
		shadow_fill = CW'(fill_sum);
	endfunction

	// Work out the result of one item and update the shadow state
	function automatic ring_result_t predict_ring_result(input logic [1:0] k,
		input logic [7:0] b, input logic [SPACE_W-1:0] s);
		ring_result_t r;
		int need;
		int adv;
		int acc;
		int len;
		int pos;
		int count;
		bit walking;
		r = '0;
		case (k)
			KIND_PUSH: begin
				if (shadow_note_left == 0) begin
					if (b != 0) begin
						// Drop the oldest records until the note fits
						need = slot_len(int'(b));
						count = 0;
						while (RING_BYTES - int'(shadow_fill) < need && shadow_fill != 0) begin
							adv = slot_len(int'(shadow_ring[shadow_tail]));
							if (adv == 0 || adv > int'(shadow_fill)) begin
								adv = int'(shadow_fill);
							end
							shadow_tail = wrap_pos(int'(shadow_tail), adv);
							shadow_fill = CW'(int'(shadow_fill) - adv);
							count++;
						end
						r.dropped = DROP_W'(count);
						shadow_ring[shadow_head] = b;
						shadow_note_left = b - 8'd1;
						if (shadow_note_left == 0) begin
							commit_shadow_note();
						end
					end
				end else begin
					pos = int'(shadow_ring[shadow_head]) - int'(shadow_note_left);
					shadow_ring[wrap_pos(int'(shadow_head), pos)] = b;
					shadow_note_left = shadow_note_left - 8'd1;
					if (shadow_note_left == 0) begin
						commit_shadow_note();
					end
				end
			end
			KIND_DRAIN: begin
				len = int'(shadow_fill);
				if (int'(s) < len) begin
					// Walk whole records up to the space limit
					pos = int'(shadow_tail);
					acc = 0;
					walking = 1'b1;
					while (walking) begin
						adv = slot_len(int'(shadow_ring[pos]));
						if (adv == 0 || acc + adv > int'(shadow_fill) || acc + adv > int'(s)) begin
							walking = 1'b0;
						end else begin
							acc += adv;
							pos = int'(wrap_pos(pos, adv));
						end
					end
					len = acc;
				end
				shadow_read_pos = shadow_tail;
				shadow_batch_left = CW'(len);
				shadow_tail = wrap_pos(int'(shadow_tail), len);
				shadow_fill = CW'(int'(shadow_fill) - len);
				r.batch = BATCH_W'(len);
			end
			KIND_READ: begin
				if (shadow_batch_left != 0) begin
					r.rd = shadow_ring[shadow_read_pos];
					shadow_read_pos = wrap_pos(int'(shadow_read_pos), 1);
					shadow_batch_left = shadow_batch_left - CW'(1);
					if (shadow_batch_left == 0) begin
						r.eob = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Compare one result field
	task automatic check_field(input string field, input logic [11:0] want,
		input logic [11:0] seen);
		if (seen !== want) begin
			$error("%s: expected %0d, got %0d", field, want, seen);
			mismatch_count++;
		end
	endtask

	// Match each result against the oldest expectation
	always @(posedge clk) begin : check_result
		ring_result_t want;
		if (arst_n && done) begin
			if (expected_ring_results.size() == 0) begin
				$error("result with no item waiting: read_byte %0d batch_bytes %0d",
					read_byte, batch_bytes);
				mismatch_count++;
			end else begin
				want = expected_ring_results.pop_front();
				check_field("read_byte", 12'(want.rd), 12'(read_byte));
				check_field("batch_bytes", 12'(want.batch), 12'(batch_bytes));
				check_field("end_of_batch", 12'(want.eob), 12'(end_of_batch));
				check_field("records_dropped", 12'(want.dropped), 12'(records_dropped));
				results_checked++;
				evicted_total += int'(want.dropped);
				if (int'(want.batch) > largest_batch) begin
					largest_batch = int'(want.batch);
				end
			end
		end
	end

	// Offer one item, idling first at random, and hold it until taken
	task automatic issue_item(input logic [1:0] k, input logic [7:0] b,
		input logic [SPACE_W-1:0] s);
		while (idle_enable && $urandom_range(99) < 23) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		note_byte <= b;
		drain_space <= s;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		if (k == KIND_UNKNOWN || (k == KIND_PUSH && b == 8'h00 && shadow_note_left == 0)) begin
			ignored_items++;
		end
		expected_ring_results.push_back(predict_ring_result(k, b, s));
		items_sent++;
	endtask

	// Hold off the sender until every result has come
	task automatic wait_for_results();
		start <= 1'b0;
		do begin
			@(posedge clk);
		end while (expected_ring_results.size() != 0);
	endtask

	// Drain limit: small in four of ten picks, spread in three, the whole ring in three
	function automatic logic [SPACE_W-1:0] random_space();
		int r;
		r = $urandom_range(9);
		if (r < 4) begin
			return SPACE_W'($urandom_range(40));
		end else if (r < 7) begin
			return SPACE_W'($urandom_range(RING_BYTES));
		end
		return SPACE_W'(RING_BYTES);
	endfunction

	// Empty ring, stray reads, short notes, partial drains and a note in progress
	task automatic test_directed_cases();
		issue_item(KIND_READ, 8'h00, '0);
		issue_item(KIND_DRAIN, 8'h00, SPACE_W'(RING_BYTES));
		issue_item(KIND_UNKNOWN, 8'hFF, SPACE_W'(RING_BYTES));
		issue_item(KIND_PUSH, 8'h00, '0);
		issue_item(KIND_PUSH, 8'd1, '0);
		issue_item(KIND_PUSH, 8'd5, '0);
		issue_item(KIND_PUSH, 8'hFF, '0);
		issue_item(KIND_PUSH, 8'h00, '0);
		issue_item(KIND_PUSH, 8'hAA, '0);
		issue_item(KIND_PUSH, 8'h55, '0);
		// Limit below the oldest record, then just one record
		issue_item(KIND_DRAIN, 8'h00, SPACE_W'(3));
		issue_item(KIND_DRAIN, 8'h00, SPACE_W'(5));
		repeat (4) issue_item(KIND_READ, 8'h00, '0);
		// Start a note, drain around it, discard a half-read batch
		issue_item(KIND_PUSH, 8'd6, '0);
		issue_item(KIND_DRAIN, 8'h00, SPACE_W'(RING_BYTES));
		repeat (2) issue_item(KIND_READ, 8'h00, '0);
		issue_item(KIND_DRAIN, 8'h00, SPACE_W'(RING_BYTES));
		issue_item(KIND_READ, 8'h00, '0);
		issue_item(KIND_PUSH, 8'h0F, '0);
		issue_item(KIND_PUSH, 8'hF0, '0);
		issue_item(KIND_PUSH, 8'h33, '0);
		issue_item(KIND_PUSH, 8'hCC, '0);
		issue_item(KIND_PUSH, 8'h7E, '0);
		issue_item(KIND_DRAIN, 8'h00, SPACE_W'(7));
	endtask

	// Fill the ring, evict many records, drain a long walk and overwrite freed bytes
	task automatic test_fill_and_evict();
		int i;
		for (i = 0; i < RING_BYTES / ALIGN_BYTES + 1; i++) begin
			issue_item(KIND_PUSH, 8'd1, '0);
		end
		issue_item(KIND_PUSH, 8'd255, '0);
		for (i = 1; i < 255; i++) begin
			issue_item(KIND_PUSH, 8'($urandom_range(255)), '0);
		end
		issue_item(KIND_DRAIN, 8'h00, SPACE_W'(RING_BYTES - 1));
		// Reuse the freed space before the batch is read
		issue_item(KIND_PUSH, 8'd12, '0);
		for (i = 1; i < 12; i++) begin
			issue_item(KIND_PUSH, 8'($urandom_range(255)), '0);
		end
		repeat (20) issue_item(KIND_READ, 8'h00, '0);
		issue_item(KIND_DRAIN, 8'h00, SPACE_W'(RING_BYTES));
		repeat (40) issue_item(KIND_READ, 8'h00, '0);
		issue_item(KIND_DRAIN, 8'h00, '0);
	endtask

	// Mostly whole notes with random content, mixed with drains, reads and noise
	task automatic test_random_traffic();
		int base;
		int done_count;
		int pick;
		int len;
		int i;
		base = items_sent - ignored_items;
		done_count = 0;
		while (done_count < RANDOM_ITEMS) begin
			idle_enable = !(done_count >= 250 && done_count < 550);
			pick = $urandom_range(99);
			if (pick < 50) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					len = $urandom_range(12, 1);
				end else if (pick < 92) begin
					len = $urandom_range(40, 13);
				end else if (pick < 98) begin
					len = $urandom_range(120, 41);
				end else begin
					len = $urandom_range(255, 121);
				end
				issue_item(KIND_PUSH, 8'(len), random_space());
				for (i = 1; i < len; i++) begin
					// Now and then drain or read in the middle of a note
					if ($urandom_range(99) < 5) begin
						issue_item($urandom_range(1) ? KIND_DRAIN : KIND_READ,
							8'($urandom_range(255)), random_space());
					end
					issue_item(KIND_PUSH, 8'($urandom_range(255)), random_space());
				end
			end else if (pick < 70) begin
				issue_item(KIND_DRAIN, 8'($urandom_range(255)), random_space());
			end else if (pick < 92) begin
				repeat ($urandom_range(24, 1)) begin
					issue_item(KIND_READ, 8'($urandom_range(255)), random_space());
				end
			end else if (pick < 95) begin
				issue_item(KIND_UNKNOWN, 8'($urandom_range(255)), random_space());
			end else if (pick < 97) begin
				issue_item(KIND_PUSH, 8'h00, random_space());
			end else if (pick < 99) begin
				issue_item(KIND_PUSH, 8'($urandom_range(255)), random_space());
			end else begin
				wait_for_results();
			end
			done_count = items_sent - ignored_items - base;
		end
		idle_enable = 1'b1;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		wait_for_results();
		test_fill_and_evict();
		wait_for_results();
		test_random_traffic();
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("sent %0d items (%0d ignored), checked %0d results in %0d cycles",
			items_sent, ignored_items, results_checked, cycle_count);
		$display("covered %0d evicted records, largest drain batch %0d bytes",
			evicted_total, largest_batch);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
